// ===== hdl/imrot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation package
// Shared types, register indexes, queue sizing and the blend function of the
// rotating frame store.
// ----------------------------------------------------------------------------
package imrot_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_Q = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_Q = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd4;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_RENDER = 1'b1;

   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W = 3;
   localparam int QCNT_W = 4;

   localparam int COORD_W = 12;

   typedef struct packed {
      logic       action;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       outside;
   } rsp_type;

   typedef struct packed {
      logic               interp_mode;
      logic signed [15:0] cos_q;
      logic signed [15:0] sin_q;
      logic [8:0]         frame_width;
      logic [8:0]         frame_height;
   } cfg_type;

   typedef struct packed {
      logic               render;
      logic               store_ok;
      logic               outside;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [7:0]         fx;
      logic [7:0]         fy;
      logic [7:0]         pixel;
   } qent_type;

   // A zero weight passes the first pixel through without touching the second.
   function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] q,
                                        input logic [7:0] w);
      logic [16:0] s;
      if (w == 8'd0) begin
         return p;
      end
      s = 17'(p) * (17'd256 - 17'(w)) + 17'(q) * 17'(w);
      return s[15:8];
   endfunction

endpackage

// ===== hdl/image_rotate_nearest_bilinear_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation unit
// Rotates a grayscale frame about its center with nearest or bilinear
// sampling; holds the configuration registers.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_stall is low and returns one
// response per render request, in order; load requests give no response.
// Registered coordinate mapping feeds an eight-entry queue, and the back end
// reads all four neighbors at once from a frame store split into four banks
// by row and column parity, then blends in two further stages. Reading a
// pixel that was never loaded returns an arbitrary value. Write the registers
// only while no request is in flight.
module image_rotate_nearest_bilinear_unit import imrot_pkg::*; #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type           cfg_ff;
   logic              q_push, q_pop, q_empty;
   qent_type          q_ent, q_head;
   logic [QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interp_mode <= MODE_BILINEAR;
         cfg_ff.cos_q <= 16'sd16384;
         cfg_ff.sin_q <= 16'sd0;
         cfg_ff.frame_width <= 9'd256;
         cfg_ff.frame_height <= 9'd256;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INTERP_MODE: cfg_ff.interp_mode <= csr_data[0];
            CSR_COS_Q: cfg_ff.cos_q <= signed'(csr_data);
            CSR_SIN_Q: cfg_ff.sin_q <= signed'(csr_data);
            CSR_FRAME_WIDTH: cfg_ff.frame_width <= csr_data[8:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   imrot_front #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .q_count(q_count),
      .q_push(q_push),
      .q_ent(q_ent)
   );

   imrot_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_ent(q_ent),
      .pop(q_pop),
      .head(q_head),
      .count(q_count),
      .empty(q_empty)
   );

   imrot_back #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(q_head),
      .empty(q_empty),
      .pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

// ===== hdl/imrot_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation front end
// Accepts requests, maps render coordinates back to source positions and
// pushes classified entries into the queue.
// ----------------------------------------------------------------------------
module imrot_front import imrot_pkg::*; #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   input  logic [QCNT_W-1:0] q_count,
   output logic              q_push,
   output qent_type          q_ent
);

   localparam int PW = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 16;
   localparam int SW = PW - FRAC_BITS;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic               accept;
   logic [QCNT_W:0]    inflight;
   logic [12:0]        fw_ext, fh_ext, w_in, h_in;
   logic signed [13:0] dx_in, dy_in, wm1_in, hm1_in;
   logic               ok_in;

   logic               v1_ff, render1_ff, near1_ff, ok1_ff;
   logic signed [13:0] dx1_ff, dy1_ff, wm11_ff, hm11_ff;
   logic [11:0]        cw1_ff, ch1_ff;
   logic [7:0]         col1_ff, row1_ff, pix1_ff;

   logic               v2_ff, render2_ff, near2_ff, ok2_ff;
   logic signed [29:0] pxa2_ff, pxb2_ff, pya2_ff, pyb2_ff;
   logic signed [13:0] wm12_ff, hm12_ff;
   logic [11:0]        cw2_ff, ch2_ff;
   logic [7:0]         col2_ff, row2_ff, pix2_ff;

   logic signed [PW-1:0] px, py, half;
   logic signed [SW-1:0] sx, sy;
   logic                 in_x, in_y;

   assign inflight = (QCNT_W+1)'(v1_ff) + (QCNT_W+1)'(v2_ff) + (QCNT_W+1)'(q_count);
   assign req_stall = inflight >= (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept = req_valid && !req_stall;

   always_comb begin
      fw_ext = 13'(cfg.frame_width);
      fh_ext = 13'(cfg.frame_height);
      w_in = (fw_ext > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : fw_ext;
      h_in = (fh_ext > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : fh_ext;
      dx_in = signed'({6'b0, req_data.col}) - signed'({2'b0, w_in[12:1]});
      dy_in = signed'({6'b0, req_data.row}) - signed'({2'b0, h_in[12:1]});
      wm1_in = signed'({1'b0, w_in}) - 14'sd1;
      hm1_in = signed'({1'b0, h_in}) - 14'sd1;
      ok_in = ({5'b0, req_data.col} < 13'(MAX_WIDTH)) &&
              ({5'b0, req_data.row} < 13'(MAX_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
      render1_ff <= req_data.action == ACTION_RENDER;
      near1_ff <= cfg.interp_mode == MODE_NEAREST;
      ok1_ff <= ok_in;
      dx1_ff <= dx_in;
      dy1_ff <= dy_in;
      wm11_ff <= wm1_in;
      hm11_ff <= hm1_in;
      cw1_ff <= w_in[12:1];
      ch1_ff <= h_in[12:1];
      col1_ff <= req_data.col;
      row1_ff <= req_data.row;
      pix1_ff <= req_data.pixel_in;

      render2_ff <= render1_ff;
      near2_ff <= near1_ff;
      ok2_ff <= ok1_ff;
      pxa2_ff <= dx1_ff * cfg.cos_q;
      pxb2_ff <= dy1_ff * cfg.sin_q;
      pya2_ff <= dy1_ff * cfg.cos_q;
      pyb2_ff <= dx1_ff * cfg.sin_q;
      wm12_ff <= wm11_ff;
      hm12_ff <= hm11_ff;
      cw2_ff <= cw1_ff;
      ch2_ff <= ch1_ff;
      col2_ff <= col1_ff;
      row2_ff <= row1_ff;
      pix2_ff <= pix1_ff;
   end

   always_comb begin
      half = signed'(PW'(near2_ff) << (FRAC_BITS - 1));
      px = PW'(pxa2_ff) + PW'(pxb2_ff) + (PW'(cw2_ff) << FRAC_BITS) + half;
      py = PW'(pya2_ff) - PW'(pyb2_ff) + (PW'(ch2_ff) << FRAC_BITS) + half;
      sx = px[PW-1:FRAC_BITS];
      sy = py[PW-1:FRAC_BITS];
      in_x = !sx[SW-1] && (sx < SW'(wm12_ff));
      in_y = !sy[SW-1] && (sy < SW'(hm12_ff));

      q_push = v2_ff;
      q_ent.render = render2_ff;
      q_ent.store_ok = ok2_ff;
      q_ent.outside = !(in_x && in_y);
      q_ent.pixel = pix2_ff;
      if (render2_ff) begin
         q_ent.x = COORD_W'(sx[XW-1:0]);
         q_ent.y = COORD_W'(sy[YW-1:0]);
      end else begin
         q_ent.x = COORD_W'(col2_ff);
         q_ent.y = COORD_W'(row2_ff);
      end
      if (near2_ff) begin
         q_ent.fx = 8'd0;
         q_ent.fy = 8'd0;
      end else begin
         q_ent.fx = px[FRAC_BITS-1 -: 8];
         q_ent.fy = py[FRAC_BITS-1 -: 8];
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
      else $error("Queue pushed while full.");

   a_stall_credit: assert property (@(posedge clock) disable iff (reset)
      accept |=> (inflight <= (QCNT_W+1)'(QUEUE_DEPTH)))
      else $error("Request accepted beyond queue credit.");

   a_nearest_weights: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && near2_ff) |-> (q_ent.fx == 8'd0 && q_ent.fy == 8'd0))
      else $error("Nearest request carries blend weights.");

endmodule

// ===== hdl/imrot_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation queue
// Short FIFO between the coordinate front end and the frame store back end.
// ----------------------------------------------------------------------------
module imrot_queue import imrot_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qent_type          push_ent,
   input  logic              pop,
   output qent_type          head,
   output logic [QCNT_W-1:0] count,
   output logic              empty
);

   qent_type          entries [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign head = entries[rd_ptr_ff];
   assign count = count_ff;
   assign empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
      if (push) begin
         entries[wr_ptr_ff] <= push_ent;
      end
   end

endmodule

// ===== hdl/imrot_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation back end
// Four parity banks of the frame store and the two blend stages, the second
// of which is the output register.
// ----------------------------------------------------------------------------
module imrot_back import imrot_pkg::*; #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic     clock,
   input  logic     reset,
   input  qent_type head,
   input  logic     empty,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW - 2;
   localparam int DEPTH = 1 << AW;

   logic          adv;
   logic [XW-1:0] hx;
   logic [YW-1:0] hy;
   logic [7:0]    rdata_ff [4];

   logic          v1_ff, render1_ff, out1_ff, sx1_ff, sy1_ff;
   logic [7:0]    fx1_ff, fy1_ff;
   logic [7:0]    p00, p01, p10, p11;

   logic          v2_ff, render2_ff, out2_ff;
   logic [7:0]    a2_ff, b2_ff, fy2_ff;

   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !empty;
   assign hx = head.x[XW-1:0];
   assign hy = head.y[YW-1:0];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam int BX = b % 2;
      localparam int BY = b / 2;
      logic [7:0]    bank_mem [DEPTH];
      logic [XW-1:0] xb;
      logic [YW-1:0] yb;
      logic          we;

      assign xb = (hx[0] == 1'(BX)) ? hx : hx + XW'(1);
      assign yb = (hy[0] == 1'(BY)) ? hy : hy + YW'(1);
      assign we = pop && !head.render && head.store_ok &&
                  hx[0] == 1'(BX) && hy[0] == 1'(BY);

      always_ff @(posedge clock) begin
         if (we) begin
            bank_mem[{hy[YW-1:1], hx[XW-1:1]}] <= head.pixel;
         end
         if (pop && head.render) begin
            rdata_ff[b] <= bank_mem[{yb[YW-1:1], xb[XW-1:1]}];
         end
      end
   end

   always_comb begin
      p00 = rdata_ff[{sy1_ff, sx1_ff}];
      p01 = rdata_ff[{sy1_ff, !sx1_ff}];
      p10 = rdata_ff[{!sy1_ff, sx1_ff}];
      p11 = rdata_ff[{!sy1_ff, !sx1_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         rsp_valid_ff <= v2_ff && render2_ff;
      end
      if (adv) begin
         render1_ff <= head.render;
         out1_ff <= head.outside;
         sx1_ff <= hx[0];
         sy1_ff <= hy[0];
         fx1_ff <= head.fx;
         fy1_ff <= head.fy;

         render2_ff <= render1_ff;
         out2_ff <= out1_ff;
         a2_ff <= blend(p00, p01, fx1_ff);
         b2_ff <= blend(p10, p11, fx1_ff);
         fy2_ff <= fy1_ff;

         rsp_data_ff.outside <= out2_ff;
         rsp_data_ff.pixel_out <= out2_ff ? 8'd255 : blend(a2_ff, b2_ff, fy2_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(v1_ff) && $stable(v2_ff)))
      else $error("Back end moved while output stalled.");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      pop |-> adv)
      else $error("Queue popped while back end stalled.");

   a_outside_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.outside) |-> (rsp_data_ff.pixel_out == 8'd255))
      else $error("Outside response without fill value.");

endmodule

// ===== tb/tb_image_rotate_nearest_bilinear_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image rotation unit testbench
// Loads frames into the rotating frame store and renders pixels at several
// angles, sizes and sampling modes. Each rendered pixel is predicted here
// and compared with the unit's response, in order, under random request gaps
// and random response stalls.
// ----------------------------------------------------------------------------
module tb_image_rotate_nearest_bilinear_unit;
   import imrot_pkg::*;

   localparam int STORE_W = 256;
   localparam int STORE_H = 256;
   localparam int FRAC = 14;
   localparam longint CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   image_rotate_nearest_bilinear_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   logic [7:0] pixel_mem [STORE_W*STORE_H];
   bit loaded [STORE_W*STORE_H];
   cfg_type cfg_now;
   rsp_type expected_pixels [$];
   int mismatches = 0;
   int renders_checked = 0;
   int loads_sent = 0;
   longint cycle_count = 0;
   bit sending_done = 1'b0;
   bit req_held = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 99) < 75) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 9) == 0) rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            renders_checked++;
            if (rsp_data.pixel_out !== want.pixel_out || rsp_data.outside !== want.outside) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected pixel %0d outside %0d, got pixel %0d outside %0d",
                           want.pixel_out, want.outside, rsp_data.pixel_out, rsp_data.outside);
            end
         end
      end
   end

   function automatic longint floor_q(longint v);
      return v >>> FRAC;
   endfunction

   function automatic logic [7:0] mix(logic [7:0] p, logic [7:0] q, logic [7:0] w);
      int unsigned s;
      s = p * (256 - w) + q * w;
      return s[15:8];
   endfunction

   function automatic rsp_type rotate_pixel(logic [7:0] col, logic [7:0] row);
      longint w, h, cw, ch, dx, dy, px, py, sx, sy, cs, sn;
      logic [7:0] fx, fy, a, b;
      rsp_type r;
      w = (cfg_now.frame_width > STORE_W) ? STORE_W : cfg_now.frame_width;
      h = (cfg_now.frame_height > STORE_H) ? STORE_H : cfg_now.frame_height;
      cs = cfg_now.cos_q;
      sn = cfg_now.sin_q;
      cw = w / 2;
      ch = h / 2;
      dx = longint'(col) - cw;
      dy = longint'(row) - ch;
      px = dx * cs + dy * sn + (cw <<< FRAC);
      py = dy * cs - dx * sn + (ch <<< FRAC);
      r.pixel_out = 8'd255;
      r.outside = 1'b1;
      if (cfg_now.interp_mode == MODE_NEAREST) begin
         sx = floor_q(px + (1 <<< (FRAC - 1)));
         sy = floor_q(py + (1 <<< (FRAC - 1)));
         if (sx >= 0 && sx < w - 1 && sy >= 0 && sy < h - 1) begin
            r.pixel_out = pixel_mem[sy*STORE_W + sx];
            r.outside = 1'b0;
         end
      end else begin
         sx = floor_q(px);
         sy = floor_q(py);
         if (sx >= 0 && sx < w - 1 && sy >= 0 && sy < h - 1) begin
            fx = 8'((px - (sx <<< FRAC)) >>> (FRAC - 8));
            fy = 8'((py - (sy <<< FRAC)) >>> (FRAC - 8));
            a = mix(pixel_mem[sy*STORE_W + sx], pixel_mem[sy*STORE_W + sx + 1], fx);
            b = mix(pixel_mem[(sy+1)*STORE_W + sx], pixel_mem[(sy+1)*STORE_W + sx + 1], fx);
            r.pixel_out = mix(a, b, fy);
            r.outside = 1'b0;
         end
      end
      return r;
   endfunction

   // True when the render falls outside the frame or every pixel it would read has been loaded.
   function automatic bit reads_loaded(logic [7:0] col, logic [7:0] row);
      cfg_type c;
      rsp_type r;
      longint w, h, cw, ch, dx, dy, px, py, sx, sy, rnd;
      c = cfg_now;
      r = rotate_pixel(col, row);
      if (r.outside) return 1'b1;
      w = (c.frame_width > STORE_W) ? STORE_W : c.frame_width;
      h = (c.frame_height > STORE_H) ? STORE_H : c.frame_height;
      cw = w / 2;
      ch = h / 2;
      dx = longint'(col) - cw;
      dy = longint'(row) - ch;
      rnd = (c.interp_mode == MODE_NEAREST) ? (1 <<< (FRAC - 1)) : 0;
      px = dx * longint'(c.cos_q) + dy * longint'(c.sin_q) + (cw <<< FRAC) + rnd;
      py = dy * longint'(c.cos_q) - dx * longint'(c.sin_q) + (ch <<< FRAC) + rnd;
      sx = floor_q(px);
      sy = floor_q(py);
      if (c.interp_mode == MODE_NEAREST) return loaded[sy*STORE_W + sx];
      return loaded[sy*STORE_W + sx] && loaded[sy*STORE_W + sx + 1] &&
             loaded[(sy+1)*STORE_W + sx] && loaded[(sy+1)*STORE_W + sx + 1];
   endfunction

   // The request valid stays high across back-to-back requests and is dropped
   // here before the sender waits on the clock.
   task automatic release_req();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         release_req();
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_request(logic act, logic [7:0] col, logic [7:0] row, logic [7:0] pix);
      req_type q;
      q.action = act;
      q.col = col;
      q.row = row;
      q.pixel_in = pix;
      req_valid <= 1'b1;
      req_data <= q;
      req_held = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACTION_LOAD) begin
         pixel_mem[row*STORE_W + col] = pix;
         loaded[row*STORE_W + col] = 1'b1;
         loads_sent++;
      end else begin
         expected_pixels.push_back(rotate_pixel(col, row));
      end
      idle_gap();
   endtask

   task automatic render(logic [7:0] col, logic [7:0] row);
      if (reads_loaded(col, row))
         send_request(ACTION_RENDER, col, row, 8'($urandom));
   endtask

   task automatic drain();
      release_req();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_INTERP_MODE: cfg_now.interp_mode = val[0];
         CSR_COS_Q: cfg_now.cos_q = val;
         CSR_SIN_Q: cfg_now.sin_q = val;
         CSR_FRAME_WIDTH: cfg_now.frame_width = val[8:0];
         CSR_FRAME_HEIGHT: cfg_now.frame_height = val[8:0];
         default: ;
      endcase
   endtask

   task automatic set_rotation(logic mode, logic [15:0] c, logic [15:0] s,
                               logic [15:0] w, logic [15:0] h);
      drain();
      write_csr(CSR_INTERP_MODE, {15'd0, mode});
      write_csr(CSR_COS_Q, c);
      write_csr(CSR_SIN_Q, s);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   task automatic test_load_frame();
      for (int r = 0; r < 24; r++)
         for (int c = 0; c < 24; c++)
            send_request(ACTION_LOAD, 8'(c), 8'(r), 8'($urandom));
      send_request(ACTION_LOAD, 8'd255, 8'd255, 8'd0);
      send_request(ACTION_LOAD, 8'd254, 8'd255, 8'd255);
      send_request(ACTION_LOAD, 8'd255, 8'd254, 8'd128);
      send_request(ACTION_LOAD, 8'd254, 8'd254, 8'd1);
      send_request(ACTION_LOAD, 8'd0, 8'd255, 8'd77);
      send_request(ACTION_LOAD, 8'd1, 8'd255, 8'd200);
   endtask

   task automatic test_directed();
      set_rotation(MODE_BILINEAR, 16'd16384, 16'd0, 16'd256, 16'd256);
      render(8'd0, 8'd0);
      render(8'd254, 8'd254);
      render(8'd255, 8'd255);
      render(8'd10, 8'd10);
      set_rotation(MODE_NEAREST, 16'd16384, 16'd0, 16'd20, 16'd20);
      render(8'd0, 8'd0);
      render(8'd18, 8'd18);
      render(8'd19, 8'd5);
      render(8'd200, 8'd3);
      set_rotation(MODE_BILINEAR, 16'd11585, 16'd11585, 16'd20, 16'd20);
      render(8'd5, 8'd7);
      render(8'd10, 8'd10);
      set_rotation(MODE_NEAREST, 16'hC000, 16'd0, 16'd20, 16'd20);
      render(8'd3, 8'd4);
      set_rotation(MODE_BILINEAR, 16'd0, 16'hC000, 16'd1, 16'd0);
      render(8'd0, 8'd0);
      set_rotation(MODE_BILINEAR, 16'hFFFF, 16'h7FFF, 16'h1FF, 16'h100);
      render(8'd128, 8'd128);
      render(8'd0, 8'd255);
      set_rotation(MODE_NEAREST, 16'h8000, 16'hFFFF, 16'd2, 16'd2);
      render(8'd1, 8'd1);
      render(8'd0, 8'd0);
   endtask

   task automatic test_random_rotations();
      int sent;
      logic [15:0] c, s;
      real ang;
      for (int phase = 0; phase < 10; phase++) begin
         ang = $urandom_range(0, 359) * 3.141592 / 180.0;
         c = 16'($rtoi($cos(ang) * 16384.0));
         s = 16'($rtoi($sin(ang) * 16384.0));
         if (phase == 9) begin
            c = 16'($urandom);
            s = 16'($urandom);
         end
         set_rotation(phase[0], c, s, 16'($urandom_range(2, 24)),
                      16'($urandom_range(2, 24)));
         if (phase == 4) send_request(ACTION_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
         sent = 0;
         while (sent < 25) begin
            if ($urandom_range(0, 9) == 0)
               send_request(ACTION_LOAD, 8'($urandom_range(0, 23)), 8'($urandom_range(0, 23)),
                            8'($urandom));
            else if ($urandom_range(0, 9) == 0)
               render(8'($urandom), 8'($urandom));
            else
               render(8'($urandom_range(0, 26)), 8'($urandom_range(0, 26)));
            sent++;
         end
      end
   endtask

   initial begin
      cfg_now.interp_mode = MODE_BILINEAR;
      cfg_now.cos_q = 16'sd16384;
      cfg_now.sin_q = 16'sd0;
      cfg_now.frame_width = 9'd256;
      cfg_now.frame_height = 9'd256;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_frame();
      test_directed();
      test_random_rotations();
      drain();
      $display("Covered %0d loads and %0d checked renders over seventeen rotation settings",
               loads_sent, renders_checked);
      $display("in both sampling modes, with tiny, oversized and arbitrary-coefficient frames.");
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
